// ===== hdl/ctl_pkg.sv =====
// Shared types and constants of the closed tour length block.
`default_nettype none
package ctl_pkg;

  localparam int COORD_W     = 16;
  localparam int COUNT_W     = 11;
  localparam int LEN_W       = 35;
  localparam int RAD_W       = 34;
  localparam int INT_PAIRS   = 17;
  localparam int JOBQ_DEPTH  = 4;
  localparam int DEF_MAX_CITIES    = 1024;
  localparam int DEF_FRACTION_BITS = 8;

  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  typedef struct packed {
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic                      last_city;
  } in_item_t;

  typedef struct packed {
    logic [LEN_W-1:0]   tour_length;
    logic [COUNT_W-1:0] city_count;
    logic               saturated;
  } out_item_t;

  // One segment to measure; close marks the segment that ends a tour.
  typedef struct packed {
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic               close;
    logic [COUNT_W-1:0] count;
  } job_t;

endpackage
`default_nettype wire

// ===== hdl/ctl_front.sv =====
// Front end: takes tour points and issues segment jobs.
`default_nettype none
module ctl_front #(
  parameter int MAX_CITIES = ctl_pkg::DEF_MAX_CITIES
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_push,
  input  wire ctl_pkg::in_item_t in_item,
  output logic                  in_full,
  output logic                  q_push,
  output ctl_pkg::job_t         q_job,
  input  wire logic             q_full
);
  import ctl_pkg::*;

  localparam int CNT_W = $clog2(MAX_CITIES + 1);

  function automatic logic [COORD_W-1:0] absdiff(input logic signed [COORD_W-1:0] a,
                                                 input logic signed [COORD_W-1:0] b);
    logic signed [COORD_W:0] d;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    if (d[COORD_W]) begin
      d = -d;
    end
    return d[COORD_W-1:0];
  endfunction

  logic signed [COORD_W-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      seg_v_r, close_v_r;
  job_t                      seg_job_r, close_job_r;

  logic                      accept;
  logic signed [COORD_W-1:0] fx, fy;
  logic [CNT_W-1:0]          cnt_inc;

  assign in_full = seg_v_r | close_v_r;
  assign accept  = in_push & ~in_full;
  assign fx      = (cnt_r == '0) ? in_item.x_coord : first_x_r;
  assign fy      = (cnt_r == '0) ? in_item.y_coord : first_y_r;
  assign cnt_inc = (cnt_r < CNT_W'(MAX_CITIES)) ? cnt_r + 1'b1 : cnt_r;

  // Issue the open segment before the closing one.
  assign q_push = seg_v_r | close_v_r;
  assign q_job  = seg_v_r ? seg_job_r : close_job_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_x_r <= '0;
      first_y_r <= '0;
      prev_x_r  <= '0;
      prev_y_r  <= '0;
      cnt_r     <= '0;
      seg_v_r   <= 1'b0;
      close_v_r <= 1'b0;
    end else begin
      if (q_push && !q_full) begin
        if (seg_v_r) begin
          seg_v_r <= 1'b0;
        end else begin
          close_v_r <= 1'b0;
        end
      end
      if (accept) begin
        first_x_r <= fx;
        first_y_r <= fy;
        prev_x_r  <= in_item.x_coord;
        prev_y_r  <= in_item.y_coord;
        cnt_r     <= in_item.last_city ? '0 : cnt_inc;
        seg_v_r   <= (cnt_r != '0);
        close_v_r <= in_item.last_city;
        seg_job_r.dx    <= absdiff(prev_x_r, in_item.x_coord);
        seg_job_r.dy    <= absdiff(prev_y_r, in_item.y_coord);
        seg_job_r.close <= 1'b0;
        seg_job_r.count <= COUNT_W'(cnt_inc);
        close_job_r.dx    <= absdiff(in_item.x_coord, fx);
        close_job_r.dy    <= absdiff(in_item.y_coord, fy);
        close_job_r.close <= 1'b1;
        close_job_r.count <= COUNT_W'(cnt_inc);
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_CITIES))
    else $error("city count beyond its limit");
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_item.last_city |=> cnt_r == '0)
    else $error("count not cleared after last city");
  a_first_no_seg: assert property (@(posedge clk) disable iff (!rst_n)
    accept && cnt_r == '0 |=> !seg_v_r)
    else $error("segment job issued for first city");
`endif

endmodule
`default_nettype wire

// ===== hdl/ctl_jobq.sv =====
// Short job queue between front end and root unit.
`default_nettype none
module ctl_jobq (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire ctl_pkg::job_t push_job,
  output logic            full,
  input  wire logic       pop,
  output ctl_pkg::job_t   pop_job,
  output logic            empty
);
  import ctl_pkg::*;

  localparam int PTR_W = $clog2(JOBQ_DEPTH);
  localparam int CNT_W = $clog2(JOBQ_DEPTH + 1);

  job_t             mem [JOBQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(JOBQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign pop_job = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

endmodule
`default_nettype wire

// ===== hdl/ctl_back.sv =====
// Back end: squares, bit-serial root, accumulation and result register.
`default_nettype none
module ctl_back #(
  parameter int FRACTION_BITS = ctl_pkg::DEF_FRACTION_BITS
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire ctl_pkg::job_t job,
  input  wire logic         job_empty,
  output logic              job_pop,
  output ctl_pkg::out_item_t out_item,
  output logic              out_empty,
  input  wire logic         out_pop
);
  import ctl_pkg::*;

  localparam int PAIRS  = INT_PAIRS + FRACTION_BITS;
  localparam int ROOT_W = PAIRS;
  localparam int REM_W  = ROOT_W + 2;
  localparam int STEP_W = $clog2(PAIRS);

  typedef enum logic [2:0] {S_IDLE, S_SQX, S_SQY, S_ROOT, S_ACC} state_t;

  state_t             state_r;
  job_t               job_r;
  logic [2*COORD_W-1:0] prod_r;
  logic [RAD_W-1:0]   rad_r;
  logic [REM_W-1:0]   rem_r;
  logic [ROOT_W-1:0]  root_r;
  logic [STEP_W-1:0]  step_r;
  logic [LEN_W-1:0]   sum_r;
  logic               sat_r;
  out_item_t          out_r;
  logic               out_v_r;

  logic [COORD_W-1:0]   mul_a;
  logic [2*COORD_W-1:0] sq;
  logic [REM_W-1:0]     rem_sh, trial;
  logic                 ge;
  logic [LEN_W:0]       sum_wide;
  logic                 sat_nxt;
  logic [LEN_W-1:0]     sum_nxt;
  logic                 slot_free;
  logic                 out_load;

  assign job_pop   = (state_r == S_IDLE) & ~job_empty;
  assign out_item  = out_r;
  assign out_empty = ~out_v_r;
  assign slot_free = ~out_v_r | out_pop;
  assign out_load  = (state_r == S_ACC) & job_r.close & slot_free;

  assign mul_a = (state_r == S_SQX) ? job_r.dx : job_r.dy;
  assign sq    = (2*COORD_W)'(mul_a) * (2*COORD_W)'(mul_a);

  assign rem_sh = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
  assign trial  = {root_r, 2'b01};
  assign ge     = (rem_sh >= trial);

  assign sum_wide = {1'b0, sum_r} + (LEN_W+1)'(root_r);
  assign sat_nxt  = sat_r | sum_wide[LEN_W];
  assign sum_nxt  = sat_nxt ? LEN_MAX : sum_wide[LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sum_r   <= '0;
      sat_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (out_pop && out_v_r) begin
        out_v_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (!job_empty) begin
            job_r   <= job;
            state_r <= S_SQX;
          end
        end
        S_SQX: begin
          prod_r  <= sq;
          state_r <= S_SQY;
        end
        S_SQY: begin
          rad_r   <= RAD_W'(prod_r) + RAD_W'(sq);
          rem_r   <= '0;
          root_r  <= '0;
          step_r  <= '0;
          state_r <= S_ROOT;
        end
        S_ROOT: begin
          rem_r  <= ge ? rem_sh - trial : rem_sh;
          root_r <= {root_r[ROOT_W-2:0], ge};
          rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(PAIRS - 1)) begin
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          if (!job_r.close) begin
            sum_r   <= sum_nxt;
            sat_r   <= sat_nxt;
            state_r <= S_IDLE;
          end else if (slot_free) begin
            out_r.tour_length <= sum_nxt;
            out_r.city_count  <= job_r.count;
            out_r.saturated   <= sat_nxt;
            sum_r   <= '0;
            sat_r   <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_sat_pins_sum: assert property (@(posedge clk) disable iff (!rst_n)
    sat_r |-> sum_r == LEN_MAX)
    else $error("saturation flag set with unsaturated sum");
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ROOT |-> step_r < STEP_W'(PAIRS))
    else $error("root step counter out of range");
  a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |=> state_r == S_SQX)
    else $error("job taken without starting work");
`endif

endmodule
`default_nettype wire

// ===== hdl/closed_tour_length_top.sv =====
// Top level of the closed Euclidean tour length block.
//
// Usage: feed the cities of a tour in visiting order as input beats
// (in_push / in_full), one point per beat, with last_city set on the final
// point. One result beat (out_empty / out_pop) follows each tour: the closed
// length in unsigned fixed point with FRACTION_BITS fraction bits, the city
// count and a sticky saturation flag.
// Structure: the front end keeps the first and previous point, turns each
// point into segment jobs (|dx|, |dy|) and queues them; the back end squares
// on one shared 16x16 multiplier and takes the root one bit per cycle.
// Jobs: each point after the first of a tour yields one segment job, and the
// last point also yields the closing segment; the back end works on one job
// at a time, so throughput is set by the single root unit.
// Reset (rst_n low, synchronous) drops any tour in progress, empties the
// job queue and the result register.
// Stall: a result waits in the output register until popped; the back end
// then holds the next closing segment, the job queue fills and in_full rises.
`default_nettype none
module closed_tour_length_top #(
  parameter int MAX_CITIES    = ctl_pkg::DEF_MAX_CITIES,
  parameter int FRACTION_BITS = ctl_pkg::DEF_FRACTION_BITS
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_push,
  input  wire ctl_pkg::in_item_t in_item,
  output logic               in_full,
  output ctl_pkg::out_item_t out_item,
  output logic               out_empty,
  input  wire logic          out_pop
);
  import ctl_pkg::*;

  // Front end to queue.
  logic q_push, q_full;
  job_t q_job;
  // Queue to back end.
  logic j_pop, j_empty;
  job_t j_job;

  // Classify points and issue segment jobs.
  ctl_front #(.MAX_CITIES(MAX_CITIES)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_item (in_item),
    .in_full (in_full),
    .q_push  (q_push),
    .q_job   (q_job),
    .q_full  (q_full)
  );

  // Decouple the two halves so each may stall on its own.
  ctl_jobq u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .full     (q_full),
    .pop      (j_pop),
    .pop_job  (j_job),
    .empty    (j_empty)
  );

  // Measure segments, accumulate and hold the result beat.
  ctl_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (j_job),
    .job_empty (j_empty),
    .job_pop   (j_pop),
    .out_item  (out_item),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

endmodule
`default_nettype wire

// ===== dv/closed_tour_length_top_tb.sv =====
// Self-checking testbench of the closed tour length block: directed and random tours.
`default_nettype none
module closed_tour_length_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ctl_pkg::*;

  // Build the block at its default sizes and mirror them here.
  localparam int TOUR_CITY_CAP = DEF_MAX_CITIES;
  localparam int FRAC_BITS     = DEF_FRACTION_BITS;

  // Drain wait follows the per-segment work of the back end; a closing point costs two segments.
  localparam int DRAIN_CYCLES  = 4 * (INT_PAIRS + FRAC_BITS + 4);
  localparam int HOLD_CYCLES   = 2500;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int IDLE_PERCENT  = 12;
  localparam int REPORT_FIRST  = 10;
  localparam int RANDOM_CITIES = 200;
  localparam int SAT_CITIES    = 1460;

  localparam logic signed [COORD_W-1:0] COORD_MIN = -32768;
  localparam logic signed [COORD_W-1:0] COORD_MAX = 32767;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_push = 1'b0;
  in_item_t  in_item = '0;
  logic      in_full;
  out_item_t out_item;
  logic      out_empty;
  logic      out_pop = 1'b0;

  closed_tour_length_top #(
    .MAX_CITIES    (TOUR_CITY_CAP),
    .FRACTION_BITS (FRAC_BITS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .out_item  (out_item),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

  // 10 ns period: low half, then high half.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Tour predictor: its own copy of the tour state, advanced once per accepted
  // input beat. Closing beats push the expected tour result onto the queue.
  // ---------------------------------------------------------------------------
  logic signed [COORD_W-1:0] tour_start_x, tour_start_y;
  logic signed [COORD_W-1:0] tour_prev_x, tour_prev_y;
  logic [LEN_W-1:0]          tour_sum;
  logic [COUNT_W-1:0]        tour_cities;
  logic                      tour_clipped;

  out_item_t tour_results_due[$];

  // floor(sqrt(rad) * 2^FRAC_BITS), one result bit per radicand bit pair.
  function automatic logic [LEN_W-1:0] fixed_root(input logic [RAD_W-1:0] rad);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] trial;
    logic [1:0]  pair;
    rem  = '0;
    root = '0;
    for (int k = 0; k < INT_PAIRS + FRAC_BITS; k++) begin
      pair = 2'b00;
      if (k < INT_PAIRS) begin
        pair = rad[2*(INT_PAIRS-1-k) +: 2];
      end
      trial = (root << 2) | 64'd1;
      rem   = (rem << 2) | 64'(pair);
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root[LEN_W-1:0];
  endfunction

  function automatic logic [LEN_W-1:0] segment_length(
    input logic signed [COORD_W-1:0] ax, ay, bx, by
  );
    int          dx;
    int          dy;
    logic [63:0] rad;
    dx = int'(ax) - int'(bx);
    dy = int'(ay) - int'(by);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    rad = 64'(dx) * 64'(dx) + 64'(dy) * 64'(dy);
    return fixed_root(rad[RAD_W-1:0]);
  endfunction

  // Add one segment; stick at the maximum once it has been hit.
  task automatic add_segment(input logic [LEN_W-1:0] seg);
    logic [LEN_W:0] total;
    total = {1'b0, tour_sum} + {1'b0, seg};
    if (tour_clipped || total > {1'b0, LEN_MAX}) begin
      tour_sum     = LEN_MAX;
      tour_clipped = 1'b1;
    end else begin
      tour_sum = total[LEN_W-1:0];
    end
  endtask

  task automatic clear_tour();
    tour_start_x = '0;
    tour_start_y = '0;
    tour_prev_x  = '0;
    tour_prev_y  = '0;
    tour_sum     = '0;
    tour_cities  = '0;
    tour_clipped = 1'b0;
  endtask

  task automatic trace_tour_city(input in_item_t city);
    out_item_t closed;
    if (tour_cities == 0) begin
      tour_start_x = city.x_coord;
      tour_start_y = city.y_coord;
    end else begin
      add_segment(segment_length(tour_prev_x, tour_prev_y, city.x_coord, city.y_coord));
    end
    tour_prev_x = city.x_coord;
    tour_prev_y = city.y_coord;
    // The count holds at the cap; lengths keep adding beyond it.
    if (tour_cities < COUNT_W'(TOUR_CITY_CAP)) begin
      tour_cities = tour_cities + 1'b1;
    end
    if (city.last_city) begin
      add_segment(segment_length(city.x_coord, city.y_coord, tour_start_x, tour_start_y));
      closed.tour_length = tour_sum;
      closed.city_count  = tour_cities;
      closed.saturated   = tour_clipped;
      tour_results_due.push_back(closed);
      tour_sum     = '0;
      tour_cities  = '0;
      tour_clipped = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Shared knobs between the test sequence and the result side. Each has one
  // writer: the test sequence asks, the result process serves.
  // ---------------------------------------------------------------------------
  logic no_idle     = 1'b0;   // suppress random gaps on both sides
  int   hold_asks   = 0;      // bumped by a test to request a long hold-off
  int   hold_served = 0;
  int   hold_left   = 0;
  int   mismatches  = 0;
  int   cycle_count = 0;

  // ---------------------------------------------------------------------------
  // Input side: offer one city beat, with random idle cycles ahead of it, and
  // hold it until the block takes it. Keep in_push high on exit so a beat that
  // follows straight away is not lowered and raised in the same step.
  // ---------------------------------------------------------------------------
  task automatic send_city(
    input logic signed [COORD_W-1:0] x,
    input logic signed [COORD_W-1:0] y,
    input logic                      last
  );
    in_item_t beat;
    beat.x_coord   = x;
    beat.y_coord   = y;
    beat.last_city = last;
    while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= beat;
    @(posedge clk);
    // in_full read here is its value at the edge just passed.
    while (in_full) @(posedge clk);
    trace_tour_city(beat);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: check every accepted beat against the oldest expected tour,
  // then decide the next pop. A hold-off drops pop until hold_left runs out.
  // ---------------------------------------------------------------------------
  task automatic log_mismatch(input string what, input out_item_t want, input out_item_t got);
    mismatches = mismatches + 1;
    if (mismatches <= REPORT_FIRST) begin
      $display("%0t %s: want len=%0d count=%0d sat=%0b, got len=%0d count=%0d sat=%0b",
               $realtime, what, want.tour_length, want.city_count, want.saturated,
               got.tour_length, got.city_count, got.saturated);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (tour_results_due.size() == 0) begin
        log_mismatch("result with no tour pending", '0, out_item);
      end else begin
        want = tour_results_due.pop_front();
        if (out_item.tour_length !== want.tour_length ||
            out_item.city_count  !== want.city_count  ||
            out_item.saturated   !== want.saturated) begin
          log_mismatch("tour result mismatch", want, out_item);
        end
      end
    end

    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_pop   <= 1'b0;
    end else if (hold_asks != hold_served) begin
      hold_served <= hold_asks;
      hold_left   <= HOLD_CYCLES;
      out_pop     <= 1'b0;
    end else begin
      out_pop <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // Watchdog: give up well past the slowest legal run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("closed_tour_length_top_tb: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // A closing city that is also the first closes onto itself: length 0, count 1.
  task automatic test_single_city_tours();
    send_city(16'sd0, 16'sd0, 1'b1);
    send_city(COORD_MAX, COORD_MIN, 1'b1);
    send_city(-16'sd1, COORD_MAX, 1'b1);
  endtask

  // Corner coordinates, full-span diagonals and axis runs, exact and
  // irrational segment lengths, repeated points.
  task automatic test_coordinate_extremes();
    send_city(COORD_MIN, COORD_MIN, 1'b0);
    send_city(COORD_MAX, COORD_MAX, 1'b0);
    send_city(COORD_MIN, COORD_MAX, 1'b0);
    send_city(COORD_MAX, COORD_MIN, 1'b1);
    send_city(16'sd5, 16'sd5, 1'b0);
    send_city(16'sd5, 16'sd5, 1'b1);
    send_city(16'sd0, 16'sd0, 1'b0);
    send_city(16'sd3, 16'sd4, 1'b0);
    send_city(16'sd0, 16'sd4, 1'b1);
    send_city(-16'sd1, -16'sd1, 1'b0);
    send_city(16'sd0, 16'sd0, 1'b1);
    send_city(COORD_MAX, 16'sd0, 1'b0);
    send_city(COORD_MIN, 16'sd0, 1'b1);
    send_city(16'sd0, COORD_MAX, 1'b0);
    send_city(16'sd0, COORD_MIN, 1'b0);
    send_city(16'sd1, 16'sd1, 1'b1);
  endtask

  // Bounce between opposite corners until the sum overflows; it must stick at
  // the maximum and the flag must stay set. The tour also runs past the city
  // cap, so the count must stop there while lengths keep adding. Follow with a
  // short tour to see the flag cleared.
  task automatic test_length_saturation();
    for (int n = 0; n < SAT_CITIES; n++) begin
      if (n[0]) send_city(COORD_MAX, COORD_MAX, n == SAT_CITIES - 1);
      else      send_city(COORD_MIN, COORD_MIN, 1'b0);
    end
    send_city(16'sd10, 16'sd20, 1'b0);
    send_city(16'sd13, 16'sd24, 1'b1);
  endtask

  // Hold the result side off for a long stretch while short tours keep coming,
  // so the job queue fills and in_full stalls the sender.
  task automatic test_result_back_pressure();
    hold_asks <= hold_asks + 1;
    for (int n = 0; n < 40; n++) begin
      send_city(16'($urandom), 16'($urandom), n % 3 == 2);
    end
  endtask

  // Pick the next city: mostly random, some near the previous city, some on
  // the edges, some repeats.
  function automatic logic signed [COORD_W-1:0] pick_coord(
    input logic signed [COORD_W-1:0] prev
  );
    int mode;
    mode = $urandom_range(9);
    if (mode <= 4) return 16'($urandom);
    if (mode <= 7) return prev + 16'(int'($urandom_range(512)) - 256);
    if (mode == 8) begin
      case ($urandom_range(3))
        0:       return COORD_MIN;
        1:       return COORD_MAX;
        2:       return 16'sd0;
        default: return -16'sd1;
      endcase
    end
    return prev;
  endfunction

  // Random tours of mostly short length, with a stretch free of idling.
  task automatic test_random_tours();
    int                        sent;
    int                        tour_len;
    int                        pick;
    logic signed [COORD_W-1:0] x, y;
    sent = 0;
    x    = '0;
    y    = '0;
    while (sent < RANDOM_CITIES) begin
      pick = $urandom_range(99);
      if (pick < 10)      tour_len = 1;
      else if (pick < 80) tour_len = $urandom_range(8, 2);
      else if (pick < 97) tour_len = $urandom_range(40, 9);
      else                tour_len = $urandom_range(120, 41);
      // Run the middle third flat out on both sides.
      no_idle <= (sent >= RANDOM_CITIES / 3) && (sent < 2 * RANDOM_CITIES / 3);
      for (int n = 0; n < tour_len; n++) begin
        x = pick_coord(x);
        y = pick_coord(y);
        send_city(x, y, n == tour_len - 1);
        sent++;
      end
    end
    no_idle <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset once, run the tests in turn, drain and report.
  // ---------------------------------------------------------------------------
  initial begin
    clear_tour();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_city_tours();
    test_coordinate_extremes();
    test_length_saturation();
    test_result_back_pressure();
    test_random_tours();

    in_push <= 1'b0;
    // Wait for every tour to come back, then watch for stray beats.
    while (tour_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("closed_tour_length_top_tb: done, clean");
    end else begin
      $display("closed_tour_length_top_tb: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
